### src/ocwsm_pkg.sv
`default_nettype none

package ocwsm_pkg;

  // Width of each wheel speed field in a result
  localparam int unsigned WheelW = 12;

  localparam logic [WheelW-1:0] WheelLimit = 12'd2000;

  // 1/sqrt(2) in Q24, pi/2 in Q30
  localparam logic [23:0] InvSqrt2Q24 = 24'd11863283;
  localparam longint unsigned HalfPiQ30 = 64'd1686629713;

  // Ceiling on the Q16 magnitude ahead of the scale multiply; any value at or
  // above it scales past the wheel limit, so clamping here is exact.
  localparam int unsigned MagW = 28;
  localparam logic [MagW-1:0] MagCap = 28'hFFF_FFFF;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_e;

endpackage

`default_nettype wire

### src/omni_chassis_wheel_speed_mix_core.sv
`default_nettype none

// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  speed, direction, turn rate, heading
// m_axis    out  m_axis_tvalid/m_axis_tready  four wheel speeds
// cfg       in   cfg_we_i                     rotation_arm (Q8.8)
//
// Seven register stages: sine ROM read, quadrant fold and speed resolve,
// heading mix multiply, sum with rotation term, magnitude, 1/sqrt(2) scale,
// saturate. One request per cycle while m_axis is not stalled.
// Each stage holds while its successor is full and stalled, so a bubble
// anywhere lets upstream requests keep moving.
// Reset clears all valid bits and sets rotation_arm to 1.0.

module omni_chassis_wheel_speed_mix_core
  import ocwsm_pkg::*;
#(
  parameter int unsigned ANGLE_BITS = 12,
  parameter int unsigned TRIG_BITS  = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,

  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,

  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  // speed_magnitude, travel_direction, turn_rate, heading, zero pad
  input  wire logic [((29 + 2 * ANGLE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,

  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // wheel0_speed, wheel1_speed, wheel2_speed, wheel3_speed
  output      logic [4 * WheelW - 1:0] m_axis_tdata
);

  localparam int unsigned AB      = ANGLE_BITS;
  localparam int unsigned TB      = TRIG_BITS;
  localparam int unsigned QUARTER = 1 << (AB - 2);
  localparam int unsigned AW      = AB - 1;
  localparam int unsigned TW      = TB + 1;
  localparam int unsigned TS      = TB + 2;
  localparam int unsigned XW      = TB + 15;
  localparam int unsigned CW      = TB + 3;
  localparam int unsigned PW      = 2 * TB + 18;
  localparam int unsigned RW      = 33;
  localparam int unsigned SH      = 2 * TB - 16;
  localparam int unsigned SW      = 2 * TB + 20;
  localparam int unsigned NST     = 7;

  localparam int unsigned DIR_LO  = 13;
  localparam int unsigned TURN_LO = 13 + AB;
  localparam int unsigned HDG_LO  = 29 + AB;

  typedef logic [TW-1:0] rom_t [QUARTER+1];

  // Quarter-wave sine in Q(TB), Taylor series to x^15 in Q30
  function automatic logic [TW-1:0] sin_quarter(input longint unsigned r);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    longint          res;
    longint          one;
    one  = longint'(1) << TB;
    x    = (r * HalfPiQ30) >> (AB - 2);
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    // each term is the last times x^2 over (2k)(2k+1), signs alternate
    term = (term * x2) / 64'd6;
    sum  = sum - longint'(term);
    term = (term * x2) / 64'd20;
    sum  = sum + longint'(term);
    term = (term * x2) / 64'd42;
    sum  = sum - longint'(term);
    term = (term * x2) / 64'd72;
    sum  = sum + longint'(term);
    term = (term * x2) / 64'd110;
    sum  = sum - longint'(term);
    term = (term * x2) / 64'd156;
    sum  = sum + longint'(term);
    term = (term * x2) / 64'd210;
    sum  = sum - longint'(term);
    if (sum < 0) begin
      sum = 0;
    end
    res = (sum + (longint'(1) << (29 - TB))) >>> (30 - TB);
    if (res > one) begin
      res = one;
    end
    return res[TW-1:0];
  endfunction

  function automatic rom_t build_rom();
    rom_t rom;
    for (int i = 0; i <= int'(QUARTER); i++) begin
      rom[i] = sin_quarter(longint'(i));
    end
    return rom;
  endfunction

  localparam rom_t DIR_ROM = build_rom();
  localparam rom_t HDG_ROM = build_rom();

  // ---------------------------------------------------------------- config
  logic [15:0] arm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arm_q <= 16'd256;
    end else if (cfg_we_i) begin
      arm_q <= cfg_wdata_i;
    end
  end

  // ---------------------------------------------------------- flow control
  logic [NST-1:0] vld_q;
  logic [NST-1:0] en;

  always_comb begin
    en[NST-1] = !vld_q[NST-1] || m_axis_tready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign s_axis_tready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // ------------------------------------------------------ stage 1: ROM read
  logic signed [12:0] in_speed;
  logic [AB-1:0]      in_dir;
  logic signed [15:0] in_turn;
  logic [AB-1:0]      in_hdg;
  logic [AW-1:0]      dir_r;
  logic [AW-1:0]      hdg_r;
  logic [AW-1:0]      dir_rc;
  logic [AW-1:0]      hdg_rc;

  assign in_speed = s_axis_tdata[12:0];
  assign in_dir   = s_axis_tdata[DIR_LO +: AB];
  assign in_turn  = s_axis_tdata[TURN_LO +: 16];
  assign in_hdg   = s_axis_tdata[HDG_LO +: AB];

  assign dir_r  = {1'b0, in_dir[AB-3:0]};
  assign hdg_r  = {1'b0, in_hdg[AB-3:0]};
  assign dir_rc = AW'(QUARTER) - dir_r;
  assign hdg_rc = AW'(QUARTER) - hdg_r;

  logic [TW-1:0]         sd1_q, cd1_q, sh1_q, ch1_q;
  quad_e                 qd1_q, qh1_q;
  logic signed [12:0]    v1_q;
  logic signed [RW-1:0]  rot1_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      sd1_q  <= DIR_ROM[dir_r];
      cd1_q  <= DIR_ROM[dir_rc];
      sh1_q  <= HDG_ROM[hdg_r];
      ch1_q  <= HDG_ROM[hdg_rc];
      qd1_q  <= quad_e'(in_dir[AB-1:AB-2]);
      qh1_q  <= quad_e'(in_hdg[AB-1:AB-2]);
      v1_q   <= in_speed;
      rot1_q <= $signed({1'b0, arm_q}) * in_turn;
    end
  end

  // ------------------------------------- stage 2: fold quadrants, resolve X/Y
  logic signed [TS-1:0] sd, cd, sh, ch;
  logic signed [TS-1:0] sdp, cdp, shp, chp;

  assign sdp = $signed({1'b0, sd1_q});
  assign cdp = $signed({1'b0, cd1_q});
  assign shp = $signed({1'b0, sh1_q});
  assign chp = $signed({1'b0, ch1_q});

  always_comb begin
    unique case (qd1_q)
      QUAD_0: begin sd = sdp;  cd = cdp;  end
      QUAD_1: begin sd = cdp;  cd = -sdp; end
      QUAD_2: begin sd = -sdp; cd = -cdp; end
      QUAD_3: begin sd = -cdp; cd = sdp;  end
      default: begin sd = sdp; cd = cdp;  end
    endcase
    unique case (qh1_q)
      QUAD_0: begin sh = shp;  ch = chp;  end
      QUAD_1: begin sh = chp;  ch = -shp; end
      QUAD_2: begin sh = -shp; ch = -chp; end
      QUAD_3: begin sh = -chp; ch = shp;  end
      default: begin sh = shp; ch = chp;  end
    endcase
  end

  logic signed [XW-1:0] x2_q, y2_q;
  logic signed [CW-1:0] p2_q, m2_q;
  logic signed [RW-1:0] rot2_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      x2_q   <= v1_q * cd;
      y2_q   <= v1_q * sd;
      p2_q   <= CW'(ch) + CW'(sh);
      m2_q   <= CW'(ch) - CW'(sh);
      rot2_q <= rot1_q;
    end
  end

  // -------------------------------------------- stage 3: heading products
  logic signed [PW-1:0] px3_q, py3_q, mx3_q, my3_q;
  logic signed [RW-1:0] rot3_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      px3_q  <= x2_q * p2_q;
      py3_q  <= y2_q * p2_q;
      mx3_q  <= x2_q * m2_q;
      my3_q  <= y2_q * m2_q;
      rot3_q <= rot2_q;
    end
  end

  // ---------------------------------- stage 4: wheel sums with rotation term
  logic signed [SW-1:0] rot_sh;
  logic signed [SW-1:0] sum4_q [4];

  assign rot_sh = SW'(rot3_q) <<< SH;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      sum4_q[0] <= SW'(my3_q) - SW'(px3_q) + rot_sh;
      sum4_q[1] <= rot_sh - SW'(mx3_q) - SW'(py3_q);
      sum4_q[2] <= SW'(px3_q) - SW'(my3_q) + rot_sh;
      sum4_q[3] <= SW'(mx3_q) + SW'(py3_q) + rot_sh;
    end
  end

  // ------------------------------- stage 5: magnitude, truncate to Q16, cap
  logic [SW-1:0]   mag   [4];
  logic [SW-1:0]   mag_t [4];
  logic [MagW-1:0] mag5_q [4];
  logic [3:0]      neg5_q;

  always_comb begin
    for (int w = 0; w < 4; w++) begin
      mag[w]   = sum4_q[w][SW-1] ? SW'(-sum4_q[w]) : SW'(sum4_q[w]);
      mag_t[w] = mag[w] >> SH;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      for (int w = 0; w < 4; w++) begin
        mag5_q[w] <= (mag_t[w] > SW'(MagCap)) ? MagCap : mag_t[w][MagW-1:0];
        neg5_q[w] <= sum4_q[w][SW-1];
      end
    end
  end

  // -------------------------------------------- stage 6: scale by 1/sqrt(2)
  logic [MagW+23:0]  prod [4];
  logic [WheelW-1:0] rpm6_q [4];
  logic [3:0]        neg6_q;

  always_comb begin
    for (int w = 0; w < 4; w++) begin
      prod[w] = {24'd0, mag5_q[w]} * {{MagW{1'b0}}, InvSqrt2Q24};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      for (int w = 0; w < 4; w++) begin
        rpm6_q[w] <= prod[w][MagW+23:40];
      end
      neg6_q <= neg5_q;
    end
  end

  // --------------------------------------- stage 7: saturate, restore sign
  logic [WheelW-1:0] lim [4];
  logic [WheelW-1:0] out7_q [4];

  always_comb begin
    for (int w = 0; w < 4; w++) begin
      lim[w] = (rpm6_q[w] > WheelLimit) ? WheelLimit : rpm6_q[w];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      for (int w = 0; w < 4; w++) begin
        out7_q[w] <= neg6_q[w] ? WheelW'(-lim[w]) : lim[w];
      end
    end
  end

  assign m_axis_tvalid = vld_q[NST-1];
  assign m_axis_tdata  = {out7_q[3], out7_q[2], out7_q[1], out7_q[0]};

  // ------------------------------------------------------------ assertions
  logic [WheelW-1:0] neg_limit;
  assign neg_limit = WheelW'(-WheelLimit);

  a_wheel_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      ($signed(out7_q[0]) <= $signed(WheelLimit)) &&
      ($signed(out7_q[0]) >= $signed(neg_limit)) &&
      ($signed(out7_q[1]) <= $signed(WheelLimit)) &&
      ($signed(out7_q[1]) >= $signed(neg_limit)) &&
      ($signed(out7_q[2]) <= $signed(WheelLimit)) &&
      ($signed(out7_q[2]) >= $signed(neg_limit)) &&
      ($signed(out7_q[3]) <= $signed(WheelLimit)) &&
      ($signed(out7_q[3]) >= $signed(neg_limit)))
    else $error("wheel speed beyond saturation limit");

  a_ready_when_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while output stage is empty");

  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output is being taken");

  a_out_follows_stage6: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NST-2] && en[NST-1] |=> m_axis_tvalid)
    else $error("request lost between scale and saturate stages");

endmodule

`default_nettype wire
